/* rtl/fixed_block_pool_allocator_macros.svh */
// Assertion macros used by the allocator port checker.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FBA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/fba_pkg.sv */
// Types and constants shared by the block pool allocator files.
package fba_pkg;

	localparam int unsigned REQ_W    = 20;
	localparam int unsigned HANDLE_W = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned LEVEL_W  = 9;

	localparam logic [REQ_W-1:0] MAX_REQ_RESET = 20'd4096;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 3'd0,
		ST_TOO_BIG = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_DOUBLE  = 3'd3,
		ST_FOREIGN = 3'd4
	} status_t;

	typedef struct packed {
		logic pop;
		logic push;
	} stack_ctl_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] top;
		logic [LEVEL_W-1:0]  depth;
	} stack_stat_t;

	typedef struct packed {
		logic set;
		logic clr;
	} map_ctl_t;

endpackage

/* rtl/fba_req_if.sv */
// Request channel: allocate or free items.
interface fba_req_if;
	import fba_pkg::*;

	logic                valid;
	logic                ready;
	logic                operation;
	logic [REQ_W-1:0]    request_bytes;
	logic [HANDLE_W-1:0] release_handle;

	modport source (output valid, operation, request_bytes, release_handle, input ready);
	modport sink   (input valid, operation, request_bytes, release_handle, output ready);
endinterface

/* rtl/fba_rsp_if.sv */
// Response channel: one result per request.
interface fba_rsp_if;
	import fba_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [HANDLE_W-1:0] granted_handle;
	logic [COUNT_W-1:0]  allocations_done;
	logic [COUNT_W-1:0]  releases_done;
	logic [LEVEL_W-1:0]  free_level;

	modport source (output valid, status, granted_handle, allocations_done, releases_done,
		free_level, input ready);
	modport sink   (input valid, status, granted_handle, allocations_done, releases_done,
		free_level, output ready);
endinterface

/* rtl/fixed_block_pool_allocator.sv */
// Fixed block pool allocator: LIFO free list, used bitmap, request and response stages.
//
//   channel | dir | transfer carries
//   --------+-----+-------------------------------------------------------------
//   req     | in  | operation, request_bytes, release_handle
//   rsp     | out | status, granted_handle, allocations_done, releases_done, free_level
//   cfg     | in  | max_request_bytes write (cfg_wr_en, cfg_wr_data)
//
// One request per cycle sustained while rsp is not stalled; the path from req transfer to rsp valid
// holds the request register, then the result register. The stack top and second entry are
// registered, so the stack memory read for a pop is issued one pop ahead.
// Reset gives a full stack (entry i holds i), an empty bitmap, zero counters.
// A stalled rsp holds its result; req takes one more item into the request stage.
module fixed_block_pool_allocator #(
	parameter int unsigned POOL_BLOCKS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	fba_req_if.sink                   req,
	fba_rsp_if.source                 rsp,
	input  logic                      cfg_wr_en,
	input  logic [fba_pkg::REQ_W-1:0] cfg_wr_data
);
	import fba_pkg::*;

	logic [REQ_W-1:0]    max_req_q;

	logic                vld_s1;
	op_t                 op_s1;
	logic [REQ_W-1:0]    bytes_s1;
	logic [HANDLE_W-1:0] handle_s1;

	logic                out_vld_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] granted_q;
	logic [COUNT_W-1:0]  allocs_q;
	logic [COUNT_W-1:0]  rels_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [COUNT_W-1:0]  alloc_cnt_q;
	logic [COUNT_W-1:0]  rel_cnt_q;

	logic                advance;
	stack_ctl_t          stk_ctl;
	stack_stat_t         stk_stat;
	map_ctl_t            map_ctl;
	logic                in_use;
	logic                alloc_ok;
	logic                free_ok;
	status_t             status_d;
	logic [LEVEL_W-1:0]  level_d;

	fba_stack #(.POOL_BLOCKS(POOL_BLOCKS)) u_stack (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (stk_ctl),
		.push_handle (handle_s1),
		.stat        (stk_stat)
	);

	fba_used_map #(.POOL_BLOCKS(POOL_BLOCKS)) u_used_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (map_ctl),
		.set_idx (stk_stat.top),
		.clr_idx (handle_s1),
		.rd_idx  (handle_s1),
		.rd_bit  (in_use)
	);

	assign advance   = vld_s1 && (!out_vld_q || rsp.ready);
	assign req.ready = !vld_s1 || advance;

	always_comb begin
		status_d = ST_OK;
		alloc_ok = 1'b0;
		free_ok  = 1'b0;
		if (op_s1 == OP_ALLOC) begin
			if (bytes_s1 > max_req_q) begin
				status_d = ST_TOO_BIG;
			end else if (stk_stat.depth == '0 || stk_stat.depth > LEVEL_W'(POOL_BLOCKS)) begin
				status_d = ST_EMPTY;
			end else begin
				alloc_ok = 1'b1;
			end
		end else begin
			if ({1'b0, handle_s1} >= LEVEL_W'(POOL_BLOCKS)) begin
				status_d = ST_FOREIGN;
			end else if (!in_use) begin
				status_d = ST_DOUBLE;
			end else begin
				free_ok = 1'b1;
			end
		end
	end

	// Drop the push on a full stack; the release still counts.
	assign stk_ctl.pop  = advance && alloc_ok;
	assign stk_ctl.push = advance && free_ok && (stk_stat.depth < LEVEL_W'(POOL_BLOCKS));
	assign map_ctl.set  = advance && alloc_ok;
	assign map_ctl.clr  = advance && free_ok;

	always_comb begin
		if (stk_ctl.pop) begin
			level_d = stk_stat.depth - 9'd1;
		end else if (stk_ctl.push) begin
			level_d = stk_stat.depth + 9'd1;
		end else begin
			level_d = stk_stat.depth;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_req_q <= MAX_REQ_RESET;
		end else if (cfg_wr_en) begin
			max_req_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (req.ready) begin
			vld_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1     <= op_t'(req.operation);
			bytes_s1  <= req.request_bytes;
			handle_s1 <= req.release_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q   <= 1'b0;
			alloc_cnt_q <= '0;
			rel_cnt_q   <= '0;
		end else begin
			if (advance) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (advance && alloc_ok) begin
				alloc_cnt_q <= alloc_cnt_q + 32'd1;
			end
			if (advance && free_ok) begin
				rel_cnt_q <= rel_cnt_q + 32'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q  <= status_d;
			granted_q <= alloc_ok ? stk_stat.top : '0;
			allocs_q  <= alloc_ok ? alloc_cnt_q + 32'd1 : alloc_cnt_q;
			rels_q    <= free_ok ? rel_cnt_q + 32'd1 : rel_cnt_q;
			level_q   <= level_d;
		end
	end

	assign rsp.valid            = out_vld_q;
	assign rsp.status           = status_q;
	assign rsp.granted_handle   = granted_q;
	assign rsp.allocations_done = allocs_q;
	assign rsp.releases_done    = rels_q;
	assign rsp.free_level       = level_q;
endmodule

/* rtl/fba_stack.sv */
// LIFO free-index stack: registered top and second entry, memory for the rest.
module fba_stack #(
	parameter int unsigned POOL_BLOCKS = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  fba_pkg::stack_ctl_t              ctl,
	input  logic [fba_pkg::HANDLE_W-1:0]     push_handle,
	output fba_pkg::stack_stat_t             stat
);
	import fba_pkg::*;

	localparam int unsigned AW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;

	logic [HANDLE_W-1:0]    mem [POOL_BLOCKS];
	logic [POOL_BLOCKS-1:0] written_q;
	logic [HANDLE_W-1:0]    top_q;
	logic [HANDLE_W-1:0]    below_q;
	logic [LEVEL_W-1:0]     depth_q;
	logic [AW-1:0]          rd_addr;
	logic [AW-1:0]          wr_addr;
	logic                   rd_en;
	logic                   wr_en;

	// Memory holds every entry below the top; the second entry is kept registered.
	assign rd_addr = AW'(depth_q - 9'd3);
	assign wr_addr = AW'(depth_q - 9'd1);
	assign rd_en   = ctl.pop && (depth_q >= 9'd3);
	assign wr_en   = ctl.push && (depth_q != '0);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= top_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			depth_q   <= LEVEL_W'(POOL_BLOCKS);
			top_q     <= HANDLE_W'(POOL_BLOCKS - 1);
			below_q   <= HANDLE_W'(POOL_BLOCKS - 2);
		end else if (ctl.pop) begin
			depth_q <= depth_q - 9'd1;
			top_q   <= below_q;
			if (rd_en) begin
				// Entry never written still holds its reset index
				below_q <= written_q[rd_addr] ? mem[rd_addr] : HANDLE_W'(rd_addr);
			end
		end else if (ctl.push) begin
			depth_q <= depth_q + 9'd1;
			top_q   <= push_handle;
			below_q <= top_q;
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
		end
	end

	assign stat.top   = top_q;
	assign stat.depth = depth_q;
endmodule

/* rtl/fba_used_map.sv */
// Used-block bitmap with one set port, one clear port and one read port.
module fba_used_map #(
	parameter int unsigned POOL_BLOCKS = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  fba_pkg::map_ctl_t            ctl,
	input  logic [fba_pkg::HANDLE_W-1:0] set_idx,
	input  logic [fba_pkg::HANDLE_W-1:0] clr_idx,
	input  logic [fba_pkg::HANDLE_W-1:0] rd_idx,
	output logic                         rd_bit
);
	import fba_pkg::*;

	localparam int unsigned AW = (POOL_BLOCKS > 1) ? $clog2(POOL_BLOCKS) : 1;

	logic [POOL_BLOCKS-1:0] used_q;
	logic                   set_ok;
	logic                   rd_ok;

	assign set_ok = ({1'b0, set_idx} < LEVEL_W'(POOL_BLOCKS));
	assign rd_ok  = ({1'b0, rd_idx} < LEVEL_W'(POOL_BLOCKS));
	assign rd_bit = rd_ok && used_q[rd_idx[AW-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			if (ctl.set && set_ok) begin
				used_q[set_idx[AW-1:0]] <= 1'b1;
			end
			if (ctl.clr) begin
				used_q[clr_idx[AW-1:0]] <= 1'b0;
			end
		end
	end
endmodule

/* rtl/fba_port_check.sv */
// Port-level checks on the allocator response channel, bound to the top level.
`include "fixed_block_pool_allocator_macros.svh"

module fba_port_check #(
	parameter int unsigned POOL_BLOCKS = 64
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [fba_pkg::STATUS_W-1:0]  status,
	input logic [fba_pkg::HANDLE_W-1:0]  granted,
	input logic [fba_pkg::COUNT_W-1:0]   allocs,
	input logic [fba_pkg::COUNT_W-1:0]   rels,
	input logic [fba_pkg::LEVEL_W-1:0]   level
);
	import fba_pkg::*;

	`FBA_ASSERT_NOW(a_grant_zero_on_fail, rsp_valid && status != ST_OK, granted == '0, "granted handle set on a failed request")
	`FBA_ASSERT_NOW(a_level_bound, rsp_valid, level <= LEVEL_W'(POOL_BLOCKS), "free level above pool size")
	`FBA_ASSERT_NOW(a_empty_level, rsp_valid && status == ST_EMPTY, level == '0, "pool empty reported with blocks on the stack")
	`FBA_ASSERT_NEXT(a_stall_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(granted) && $stable(allocs) && $stable(rels) && $stable(level), "stalled response changed")
endmodule

bind fixed_block_pool_allocator fba_port_check #(.POOL_BLOCKS(POOL_BLOCKS)) u_port_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.status    (rsp.status),
	.granted   (rsp.granted_handle),
	.allocs    (rsp.allocations_done),
	.rels      (rsp.releases_done),
	.level     (rsp.free_level)
);
